// ===== rtl/ssc_pkg.sv =====
package ssc_pkg;

  localparam int CoordBits = 24;
  localparam int FracBits  = 8;
  localparam int CfgBits   = 13;
  localparam int CfgIdxBits = 1;
  // quotient magnitude saturates at 2**QuotBits
  localparam int QuotBits  = 41;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgHeight = 1'b0,
    CfgWidth  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x_in;
    logic signed [CoordBits-1:0] start_y_in;
    logic signed [CoordBits-1:0] end_x_in;
    logic signed [CoordBits-1:0] end_y_in;
  } seg_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x_out;
    logic signed [CoordBits-1:0] start_y_out;
    logic signed [CoordBits-1:0] end_x_out;
    logic signed [CoordBits-1:0] end_y_out;
    logic                        degenerate;
  } seg_out_t;

endpackage

// ===== rtl/ssc_div.sv =====
// Two-lane pipelined trunc(a*b/c): abs, multiply, overflow check, one quotient bit per stage.
module ssc_div #(
  parameter int AW  = 26,
  parameter int SBW = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic signed [AW-1:0]                 a_i [2],
  input  logic signed [AW-1:0]                 b_i,
  input  logic signed [AW-1:0]                 c_i,
  input  logic [SBW-1:0]                       sb_i,
  output logic                                 valid_o,
  output logic signed [ssc_pkg::QuotBits+1:0]  q_o [2],
  output logic [SBW-1:0]                       sb_o
);

  localparam int QB = ssc_pkg::QuotBits;
  localparam int QW = QB + 2;
  localparam int PW = (2 * AW > QB + 1) ? 2 * AW : QB + 1;

  logic [AW-1:0] abs_a [2];
  logic [AW-1:0] abs_b, abs_c;
  logic [1:0]    neg;

  logic          va_q, vm_q;
  logic [AW-1:0] ma_q [2];
  logic [AW-1:0] mb_q, mc_q, pc_q;
  logic [1:0]    na_q, nm_q;
  logic [SBW-1:0] sba_q, sbm_q;
  logic [PW-1:0] p_q [2];
  logic [PW-1:0] hi_d [2];

  logic          bv_q  [QB+1];
  logic [AW-1:0] br_q  [QB+1][2];
  logic [QB-1:0] bq_q  [QB+1][2];
  logic [QB-1:0] blo_q [QB+1][2];
  logic [1:0]    bov_q [QB+1];
  logic [1:0]    bn_q  [QB+1];
  logic [AW-1:0] bc_q  [QB+1];
  logic [SBW-1:0] bsb_q [QB+1];

  logic [AW-1:0] rs_d [QB][2];
  logic          ge_d [QB][2];

  logic [QB:0]          mag [2];
  logic signed [QW-1:0] smag [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      abs_a[l] = a_i[l][AW-1] ? AW'(-a_i[l]) : AW'(a_i[l]);
      neg[l]   = a_i[l][AW-1] ^ b_i[AW-1] ^ c_i[AW-1];
    end
    abs_b = b_i[AW-1] ? AW'(-b_i) : AW'(b_i);
    abs_c = c_i[AW-1] ? AW'(-c_i) : AW'(c_i);
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi_d[l] = p_q[l] >> QB;
    end
  end

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      for (int l = 0; l < 2; l++) begin
        rs_d[j][l] = {br_q[j][l][AW-2:0], blo_q[j][l][QB-1]};
        ge_d[j][l] = rs_d[j][l] >= bc_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vm_q <= 1'b0;
      for (int j = 0; j <= QB; j++) begin
        bv_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      va_q    <= valid_i;
      vm_q    <= va_q;
      bv_q[0] <= vm_q;
      for (int j = 0; j < QB; j++) begin
        bv_q[j+1] <= bv_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        ma_q[l] <= abs_a[l];
        p_q[l]  <= PW'((2 * AW)'(ma_q[l]) * (2 * AW)'(mb_q));
      end
      mb_q  <= abs_b;
      mc_q  <= abs_c;
      na_q  <= neg;
      sba_q <= sb_i;
      pc_q  <= mc_q;
      nm_q  <= na_q;
      sbm_q <= sba_q;

      for (int l = 0; l < 2; l++) begin
        br_q[0][l]  <= AW'(hi_d[l]);
        bq_q[0][l]  <= '0;
        blo_q[0][l] <= p_q[l][QB-1:0];
        bov_q[0][l] <= hi_d[l] >= PW'(pc_q);
      end
      bn_q[0]  <= nm_q;
      bc_q[0]  <= pc_q;
      bsb_q[0] <= sbm_q;

      for (int j = 0; j < QB; j++) begin
        for (int l = 0; l < 2; l++) begin
          br_q[j+1][l]  <= ge_d[j][l] ? rs_d[j][l] - bc_q[j] : rs_d[j][l];
          bq_q[j+1][l]  <= {bq_q[j][l][QB-2:0], ge_d[j][l]};
          blo_q[j+1][l] <= blo_q[j][l] << 1;
        end
        bov_q[j+1] <= bov_q[j];
        bn_q[j+1]  <= bn_q[j];
        bc_q[j+1]  <= bc_q[j];
        bsb_q[j+1] <= bsb_q[j];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l]  = bov_q[QB][l] ? {1'b1, {QB{1'b0}}} : {1'b0, bq_q[QB][l]};
      smag[l] = $signed({1'b0, mag[l]});
      q_o[l]  = bn_q[QB][l] ? -smag[l] : smag[l];
    end
  end

  assign valid_o = bv_q[QB];
  assign sb_o    = bsb_q[QB];

endmodule

// ===== rtl/ssc_skid.sv =====
// Two-entry output buffer; room_o comes straight from the fill count.
module ssc_skid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ssc_pkg::seg_out_t  data_i,
  output logic               room_o,
  output logic               valid_o,
  input  logic               ready_i,
  output ssc_pkg::seg_out_t  data_o
);

  logic [1:0]        cnt_q, cnt_d;
  logic              wp_q, rp_q;
  logic              pop;
  ssc_pkg::seg_out_t mem_q [2];

  assign valid_o = cnt_q != 2'd0;
  assign room_o  = cnt_q != 2'd2;
  assign pop     = valid_o & ready_i;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== rtl/segment_screen_clipper_top.sv =====
// Channel | Direction | Signals                              | Item
// in      | input     | in_valid_i, in_ready_o, in_data_i    | seg_in_t, one segment
// out     | output    | out_valid_o, out_ready_i, out_data_o | seg_out_t, clipped segment
// cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i      | height / width register
//
// One segment per cycle while the output buffer has room; the path from input accept to out_valid_o
// runs through two chained 44-stage multiply-divide pipelines (one quotient bit a stage).
// Reset: height 480, width 800, pipeline and output buffer empty.
// The whole pipeline holds while the two-entry output buffer is full; in_ready_o then drops.
module segment_screen_clipper_top #(
  parameter int FRAC_BITS = ssc_pkg::FracBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  ssc_pkg::seg_in_t                       in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output ssc_pkg::seg_out_t                      out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [ssc_pkg::CfgIdxBits-1:0]         cfg_idx_i,
  input  logic [ssc_pkg::CfgBits-1:0]            cfg_data_i
);

  localparam int C  = ssc_pkg::CoordBits;
  localparam int EB = ssc_pkg::CfgBits + FRAC_BITS;
  localparam int AW = ((C > EB) ? C : EB) + 2;
  localparam int QW = ssc_pkg::QuotBits + 2;
  localparam int XW = QW + 1;

  typedef struct packed {
    logic signed [C-1:0]  x1;
    logic signed [C-1:0]  y1;
    logic signed [C-1:0]  x2;
    logic signed [C-1:0]  y2;
    logic signed [AW-1:0] dx;
    logic signed [AW-1:0] dy;
    logic [1:0]           clip;
    logic [1:0]           top;
  } seg_sb_t;

  typedef struct packed {
    seg_sb_t              seg;
    logic [1:0][XW-1:0]   xc;
    logic [1:0]           xlo;
    logic [1:0]           xhi;
  } cross_sb_t;

  logic [ssc_pkg::CfgBits-1:0] cfg_h_q, cfg_w_q;
  logic signed [AW-1:0]        h_s, w_s;
  logic                        en;

  // stage 1
  seg_sb_t              s1_d, s1_q;
  logic signed [AW-1:0] n1_d [2];
  logic signed [AW-1:0] n1_q [2];
  logic                 v1_q;
  logic signed [AW-1:0] py1;
  logic                 above, below;

  // first division
  logic                 d1_v;
  logic signed [QW-1:0] d1_q [2];
  logic [$bits(seg_sb_t)-1:0] d1_sb;
  seg_sb_t              d1_seg;

  // crossing stage
  cross_sb_t            sx_d, sx_q;
  logic signed [AW-1:0] n2_d [2];
  logic signed [AW-1:0] n2_q [2];
  logic                 vx_q;
  logic signed [XW-1:0] xcr;
  logic signed [AW-1:0] bnd;

  // second division
  logic                 d2_v;
  logic signed [QW-1:0] d2_q [2];
  logic [$bits(cross_sb_t)-1:0] d2_sb;
  cross_sb_t            cs;

  // final select
  logic signed [XW-1:0] px, py, ee, wx, xl;
  logic signed [XW-1:0] ox [2];
  logic signed [XW-1:0] oy [2];
  logic                 deg_d;
  ssc_pkg::seg_out_t    res;

  function automatic logic signed [C-1:0] sat_c(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi, lo;
    hi = $signed({{(XW-C+1){1'b0}}, {(C-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[C-1:0];
    end else if (v < lo) begin
      return lo[C-1:0];
    end
    return v[C-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q <= ssc_pkg::CfgBits'(480);
      cfg_w_q <= ssc_pkg::CfgBits'(800);
    end else if (cfg_we_i) begin
      unique case (ssc_pkg::cfg_idx_e'(cfg_idx_i))
        ssc_pkg::CfgHeight: cfg_h_q <= cfg_data_i;
        ssc_pkg::CfgWidth:  cfg_w_q <= cfg_data_i;
      endcase
    end
  end

  assign h_s = $signed(AW'(cfg_h_q) << FRAC_BITS);
  assign w_s = $signed(AW'(cfg_w_q) << FRAC_BITS);

  assign in_ready_o = en;

  // stage 1: deltas, clip edge per endpoint, edge minus y1
  always_comb begin
    s1_d.x1 = in_data_i.start_x_in;
    s1_d.y1 = in_data_i.start_y_in;
    s1_d.x2 = in_data_i.end_x_in;
    s1_d.y2 = in_data_i.end_y_in;
    s1_d.dx = AW'(in_data_i.end_x_in) - AW'(in_data_i.start_x_in);
    s1_d.dy = AW'(in_data_i.end_y_in) - AW'(in_data_i.start_y_in);
    for (int l = 0; l < 2; l++) begin
      py1 = (l == 0) ? AW'(in_data_i.start_y_in) : AW'(in_data_i.end_y_in);
      above = py1 > h_s;
      below = py1[AW-1];
      s1_d.clip[l] = above | below;
      s1_d.top[l]  = above;
      n1_d[l] = (above ? h_s : AW'(0)) - AW'(in_data_i.start_y_in);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vx_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      vx_q <= d1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      n1_q <= n1_d;
      sx_q <= sx_d;
      n2_q <= n2_d;
    end
  end

  ssc_div #(
    .AW  (AW),
    .SBW ($bits(seg_sb_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .a_i     (n1_q),
    .b_i     (s1_q.dx),
    .c_i     (s1_q.dy),
    .sb_i    (s1_q),
    .valid_o (d1_v),
    .q_o     (d1_q),
    .sb_o    (d1_sb)
  );

  assign d1_seg = seg_sb_t'(d1_sb);

  // crossing x, side test, vertical edge minus x1
  always_comb begin
    sx_d.seg = d1_seg;
    for (int l = 0; l < 2; l++) begin
      xcr = XW'(d1_seg.x1) + XW'(d1_q[l]);
      sx_d.xc[l]  = xcr;
      sx_d.xlo[l] = xcr[XW-1];
      sx_d.xhi[l] = xcr > XW'(w_s);
      bnd = xcr[XW-1] ? AW'(0) : w_s;
      n2_d[l] = bnd - AW'(d1_seg.x1);
    end
  end

  ssc_div #(
    .AW  (AW),
    .SBW ($bits(cross_sb_t))
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vx_q),
    .a_i     (n2_q),
    .b_i     (sx_q.seg.dy),
    .c_i     (sx_q.seg.dx),
    .sb_i    (sx_q),
    .valid_o (d2_v),
    .q_o     (d2_q),
    .sb_o    (d2_sb)
  );

  assign cs = cross_sb_t'(d2_sb);

  always_comb begin
    deg_d = 1'b0;
    wx = XW'(w_s);
    for (int l = 0; l < 2; l++) begin
      px = (l == 0) ? XW'(cs.seg.x1) : XW'(cs.seg.x2);
      py = (l == 0) ? XW'(cs.seg.y1) : XW'(cs.seg.y2);
      ee = cs.seg.top[l] ? XW'(h_s) : XW'(0);
      xl = $signed(cs.xc[l]);
      if (!cs.seg.clip[l]) begin
        ox[l] = px;
        oy[l] = py;
      end else if (cs.seg.dy == '0) begin
        // horizontal segment or single point
        ox[l] = px[XW-1] ? XW'(0) : ((px > wx) ? wx : px);
        oy[l] = ee;
        deg_d = 1'b1;
      end else if (!(cs.xlo[l] || cs.xhi[l])) begin
        ox[l] = xl;
        oy[l] = ee;
      end else begin
        ox[l] = cs.xlo[l] ? XW'(0) : wx;
        if (cs.seg.dx == '0) begin
          oy[l] = ee;
          deg_d = 1'b1;
        end else begin
          oy[l] = XW'(cs.seg.y1) + XW'(d2_q[l]);
        end
      end
    end
    res.start_x_out = sat_c(ox[0]);
    res.start_y_out = sat_c(oy[0]);
    res.end_x_out   = sat_c(ox[1]);
    res.end_y_out   = sat_c(oy[1]);
    res.degenerate  = deg_d;
  end

  ssc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (d2_v & en),
    .data_i  (res),
    .room_o  (en),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("pipeline stalled with empty output buffer");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && !out_ready_i) |=> !in_ready_o)
    else $error("output buffer lost an item while stalled");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int Latency = 91;
  localparam longint CoordHi = (64'sd1 <<< (ssc_pkg::CoordBits - 1)) - 1;
  localparam longint CoordLo = -(64'sd1 <<< (ssc_pkg::CoordBits - 1));
  localparam longint QuotLim = 64'sd1 <<< ssc_pkg::QuotBits;
  localparam int HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ssc_pkg::seg_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ssc_pkg::seg_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [ssc_pkg::CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [ssc_pkg::CfgBits-1:0] cfg_data_i = '0;

  segment_screen_clipper_top i_dut (.*);

  always #2 clk_i = ~clk_i;

  ssc_pkg::seg_in_t segs_pending[$];
  ssc_pkg::seg_out_t clips_expected[$];
  logic [ssc_pkg::CfgBits-1:0] cur_height = 13'd480;
  logic [ssc_pkg::CfgBits-1:0] cur_width = 13'd800;
  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  bit hold_req = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  longint cycles = 0;

  // trunc(a*b/c), magnitude clamped
  function automatic longint scale_div(longint a, longint b, longint c);
    logic signed [127:0] p;
    logic signed [127:0] q;
    p = 128'(signed'(a)) * 128'(signed'(b));
    q = p / 128'(signed'(c));
    if (q > 128'(QuotLim)) return QuotLim;
    if (q < -128'(QuotLim)) return -QuotLim;
    return longint'(q);
  endfunction

  function automatic logic [ssc_pkg::CoordBits-1:0] clamp_coord(longint v);
    if (v > CoordHi) v = CoordHi;
    if (v < CoordLo) v = CoordLo;
    return v[ssc_pkg::CoordBits-1:0];
  endfunction

  function automatic void clip_end(input longint px, py, x1, y1, dx, dy, h, w,
                                   output longint ox, oy, inout bit deg);
    longint e, x, y, edg;
    if (py > h) e = h;
    else if (py < 0) e = 0;
    else begin
      ox = px;
      oy = py;
      return;
    end
    y = e;
    if (dy == 0) begin
      x = px;
      if (x < 0) x = 0;
      if (x > w) x = w;
      deg = 1'b1;
    end else begin
      x = (dx == 0) ? x1 : x1 + scale_div(e - y1, dx, dy);
      if (x < 0 || x > w) begin
        edg = (x < 0) ? 0 : w;
        if (dx == 0) deg = 1'b1;
        else y = y1 + scale_div(edg - x1, dy, dx);
        x = edg;
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic ssc_pkg::seg_out_t clip_segment(ssc_pkg::seg_in_t s);
    longint x1, y1, x2, y2, h, w, ax, ay, bx, by;
    bit deg;
    ssc_pkg::seg_out_t r;
    x1 = s.start_x_in;
    y1 = s.start_y_in;
    x2 = s.end_x_in;
    y2 = s.end_y_in;
    h = longint'(cur_height) << ssc_pkg::FracBits;
    w = longint'(cur_width) << ssc_pkg::FracBits;
    deg = 1'b0;
    clip_end(x1, y1, x1, y1, x2 - x1, y2 - y1, h, w, ax, ay, deg);
    clip_end(x2, y2, x1, y1, x2 - x1, y2 - y1, h, w, bx, by, deg);
    r.start_x_out = clamp_coord(ax);
    r.start_y_out = clamp_coord(ay);
    r.end_x_out = clamp_coord(bx);
    r.end_y_out = clamp_coord(by);
    r.degenerate = deg;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // handshakes seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    out_taken <= out_valid_o && out_ready_i;
  end

  // driver
  always @(negedge clk_i) begin
    ssc_pkg::seg_in_t seg;
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // item still waiting
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (segs_pending.size() > 0) begin
        seg = segs_pending.pop_front();
        in_data_i <= seg;
        clips_expected.insert(clips_expected.size(), clip_segment(seg));
        in_valid_i <= 1'b1;
        send_gap <= $urandom_range(0, 12);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    int gap;
    if (hold_req && hold_cnt < HoldCycles) begin
      hold_cnt <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else if (out_taken) begin
      gap = $urandom_range(0, 12);
      recv_gap <= gap;
      out_ready_i <= (gap == 0);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready_i <= (recv_gap == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ssc_pkg::seg_out_t exp_clip;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (clips_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", out_data_o);
      end else begin
        exp_clip = clips_expected.pop_front();
        if (out_data_o !== exp_clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %0d %0b / got %0d %0d %0d %0d %0b",
                     exp_clip.start_x_out, exp_clip.start_y_out, exp_clip.end_x_out,
                     exp_clip.end_y_out, exp_clip.degenerate, out_data_o.start_x_out,
                     out_data_o.start_y_out, out_data_o.end_x_out, out_data_o.end_y_out,
                     out_data_o.degenerate);
        end
      end
    end
  end

  function automatic logic [ssc_pkg::CoordBits-1:0] rand_coord(int mode);
    case (mode)
      0: return ssc_pkg::CoordBits'($urandom());
      1: return ssc_pkg::CoordBits'($urandom_range(0, 1200 << ssc_pkg::FracBits))
                - ssc_pkg::CoordBits'(100 << ssc_pkg::FracBits);
      2: return $urandom_range(0, 1)
                ? ssc_pkg::CoordBits'(CoordHi - longint'($urandom_range(0, 3)))
                : ssc_pkg::CoordBits'(CoordLo + longint'($urandom_range(0, 3)));
      default: return ssc_pkg::CoordBits'($urandom_range(0, 4000))
                      - ssc_pkg::CoordBits'(2000);
    endcase
  endfunction

  task automatic drain(input bit settle);
    while (segs_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (clips_expected.size() != 0) @(posedge clk_i);
    if (settle) repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_cfg(ssc_pkg::cfg_idx_e idx, logic [ssc_pkg::CfgBits-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ssc_pkg::CfgHeight) cur_height = val;
    else cur_width = val;
  endtask

  task automatic add_seg(logic [ssc_pkg::CoordBits-1:0] a, b, c, d);
    ssc_pkg::seg_in_t s;
    s.start_x_in = a;
    s.start_y_in = b;
    s.end_x_in = c;
    s.end_y_in = d;
    segs_pending.insert(segs_pending.size(), s);
  endtask

  task automatic add_random(int n);
    int m;
    logic [ssc_pkg::CoordBits-1:0] c0, c1;
    repeat (n) begin
      m = $urandom_range(0, 9);
      c0 = rand_coord(m < 6 ? 1 : m < 8 ? 0 : m == 8 ? 2 : 3);
      c1 = rand_coord(m < 6 ? 1 : m < 8 ? 0 : m == 8 ? 2 : 3);
      case ($urandom_range(0, 7))
        0: add_seg(c0, c1, rand_coord(1), c1);
        1: add_seg(c0, c1, c0, rand_coord(1));
        default: add_seg(c0, c1, rand_coord(m < 6 ? 1 : 0), rand_coord(m < 6 ? 1 : 0));
      endcase
    end
  endtask

  initial begin
    logic [ssc_pkg::CfgBits-1:0] heights[5];
    logic [ssc_pkg::CfgBits-1:0] widths[5];
    heights = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd480};
    widths = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd800};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // inside, vertical, horizontal, point, extremes
    add_seg(24'h001000, 24'h001000, 24'h002000, 24'h003000);
    add_seg(24'h001000, -24'sh1000, 24'h001000, 24'h040000);
    add_seg(24'h7FFFFF, -24'sh1000, 24'h7FFFFF, 24'h040000);
    add_seg(-24'sh1000, -24'sh1000, -24'sh1000, 24'h040000);
    add_seg(24'h001000, -24'sh1000, 24'h002000, -24'sh1000);
    add_seg(-24'sh5000, 24'h040000, 24'h090000, 24'h040000);
    add_seg(24'h001000, 24'h7FFFFF, 24'h001000, 24'h7FFFFF);
    add_seg(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    add_seg(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
    add_seg(24'hFFFFFF, 24'h000000, 24'h000001, 24'hFFFFFF);
    add_seg(24'h000000, 24'h800000, 24'h000001, 24'h7FFFFF);
    add_seg(-24'sh10000, -24'sh100, 24'h100000, 24'h030000);
    add_seg(24'h0A0000, 24'h020000, 24'h000100, 24'h030000);
    add_seg(24'h032000, 24'h01E000, 24'h000000, 24'h000000);
    drain(1'b0);
    add_random(60);
    drain(1'b0);
    hold_req = 1'b1;
    add_random(80);
    drain(1'b1);
    for (int k = 0; k < 5; k++) begin
      write_cfg(ssc_pkg::CfgHeight, heights[k]);
      write_cfg(ssc_pkg::CfgWidth, widths[k]);
      add_random(72);
      drain(1'b1);
    end
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
